@@ design/skit_pkg.sv @@
package skit_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int REC_W    = 16;
  localparam int ENT_W    = KEY_W + REC_W;
  localparam int OP_W     = 3;
  localparam int STS_W    = 2;
  localparam int IN_DW    = ((ENT_W + 7) / 8) * 8;
  localparam int OUT_DW   = ((ENT_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_FIRST  = 3'd4
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CK,
    S_DECIDE,
    S_SHU_RD,
    S_SHU_WR,
    S_PUT,
    S_SHD_RD,
    S_SHD_WR,
    S_FIRST_CK,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_JDN,
    RD_JUP,
    RD_ZERO
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    logic    pos_ld;
    logic    pos_hit;
    logic    j_ld_cnt;
    logic    j_ld_pos;
    logic    j_dec;
    logic    j_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    res_ld;
    status_t res_status;
    logic    res_found;
    logic    out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_end;
    logic            key_gt;
    logic            match;
    logic            full;
    logic            empty;
    logic            j_gt_pos;
    logic            j1_lt_cnt;
    logic            out_free;
  } dp_sts_t;

endpackage

@@ design/skit_ctrl.sv @@
module skit_ctrl
  import skit_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_INSERT, OP_DELETE, OP_LOOKUP: state_nxt = S_SCAN_RD;
          OP_FIRST: state_nxt = sts.empty ? S_RESULT : S_FIRST_CK;
          default: state_nxt = S_RESULT;
        endcase
      end
      S_SCAN_RD: begin
        state_nxt = sts.idx_end ? S_DECIDE : S_SCAN_CK;
      end
      S_SCAN_CK: begin
        state_nxt = sts.key_gt ? S_SCAN_RD : S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts.op == OP_INSERT && !sts.match && !sts.full) begin
          state_nxt = S_SHU_RD;
        end else if (sts.op == OP_DELETE && sts.match) begin
          state_nxt = S_SHD_RD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SHU_RD: state_nxt = sts.j_gt_pos ? S_SHU_WR : S_PUT;
      S_SHU_WR: state_nxt = S_SHU_RD;
      S_PUT: state_nxt = S_RESULT;
      S_SHD_RD: state_nxt = sts.j1_lt_cnt ? S_SHD_WR : S_RESULT;
      S_SHD_WR: state_nxt = S_SHD_RD;
      S_FIRST_CK: state_nxt = S_RESULT;
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_IDX;
    cmd.res_status = ST_OK;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_INSERT, OP_DELETE, OP_LOOKUP: cmd.idx_clr = 1'b1;
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.res_ld = 1'b1;
            cmd.res_status = ST_OK;
          end
          OP_FIRST: begin
            if (sts.empty) begin
              cmd.res_ld = 1'b1;
              cmd.res_status = ST_MISS;
            end else begin
              cmd.rd_en = 1'b1;
              cmd.rd_sel = RD_ZERO;
            end
          end
          default: begin
            cmd.res_ld = 1'b1;
            cmd.res_status = ST_MISS;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (sts.idx_end) begin
          cmd.pos_ld = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_IDX;
        end
      end
      S_SCAN_CK: begin
        if (sts.key_gt) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.pos_ld = 1'b1;
          cmd.pos_hit = 1'b1;
        end
      end
      S_DECIDE: begin
        unique case (sts.op)
          OP_INSERT: begin
            if (sts.match) begin
              cmd.res_ld = 1'b1;
              cmd.res_status = ST_DUP;
            end else if (sts.full) begin
              cmd.res_ld = 1'b1;
              cmd.res_status = ST_FULL;
            end else begin
              cmd.j_ld_cnt = 1'b1;
            end
          end
          OP_DELETE: begin
            if (sts.match) begin
              cmd.j_ld_pos = 1'b1;
            end else begin
              cmd.res_ld = 1'b1;
              cmd.res_status = ST_MISS;
            end
          end
          default: begin
            cmd.res_ld = 1'b1;
            cmd.res_status = sts.match ? ST_OK : ST_MISS;
            cmd.res_found = sts.match;
          end
        endcase
      end
      S_SHU_RD: begin
        if (sts.j_gt_pos) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_JDN;
        end
      end
      S_SHU_WR: begin
        cmd.wr_en = 1'b1;
        cmd.j_dec = 1'b1;
      end
      S_PUT: begin
        cmd.wr_en = 1'b1;
        cmd.wr_new = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.res_ld = 1'b1;
        cmd.res_status = ST_OK;
      end
      S_SHD_RD: begin
        if (sts.j1_lt_cnt) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_JUP;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.res_ld = 1'b1;
          cmd.res_status = ST_OK;
        end
      end
      S_SHD_WR: begin
        cmd.wr_en = 1'b1;
        cmd.j_inc = 1'b1;
      end
      S_FIRST_CK: begin
        cmd.res_ld = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_found = 1'b1;
      end
      S_RESULT: begin
        cmd.out_ld = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/skit_dp.sv @@
module skit_dp
  import skit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [OP_W-1:0]   in_tuser,
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [STS_W-1:0]  out_tuser,
  output logic [OUT_DW-1:0] out_tdata
);

  logic [ENT_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [REC_W-1:0] rec_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] pos_r;
  logic             match_r;
  logic [CNT_W-1:0] j_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ENT_W-1:0] rdata_r;
  status_t          res_status_r;
  logic [KEY_W-1:0] res_key_r;
  logic [REC_W-1:0] res_rec_r;
  logic             out_valid_r, out_valid_nxt;
  logic [STS_W-1:0] out_status_r;
  logic [KEY_W-1:0] out_key_r;
  logic [REC_W-1:0] out_rec_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [KEY_W-1:0] rkey;
  logic [REC_W-1:0] rrec;
  logic [CNT_W-1:0] j_dn;
  logic [CNT_W-1:0] j_up;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  assign rkey = rdata_r[KEY_W-1:0];
  assign rrec = rdata_r[ENT_W-1:KEY_W];
  assign j_dn = j_r - CNT_W'(1);
  assign j_up = j_r + CNT_W'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:  rd_addr = idx_r[IDX_W-1:0];
      RD_JDN:  rd_addr = j_dn[IDX_W-1:0];
      RD_JUP:  rd_addr = j_up[IDX_W-1:0];
      RD_ZERO: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  assign wr_addr = cmd.wr_new ? pos_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign wr_data = cmd.wr_new ? {rec_r, key_r} : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[KEY_W-1:0];
      rec_r <= in_tdata[ENT_W-1:KEY_W];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.pos_ld) begin
      pos_r   <= idx_r;
      match_r <= cmd.pos_hit && (key_r == rkey);
    end
    priority if (cmd.j_ld_cnt) begin
      j_r <= cnt_r;
    end else if (cmd.j_ld_pos) begin
      j_r <= pos_r;
    end else if (cmd.j_dec) begin
      j_r <= j_dn;
    end else if (cmd.j_inc) begin
      j_r <= j_up;
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      res_key_r    <= cmd.res_found ? rkey : '0;
      res_rec_r    <= cmd.res_found ? rrec : '0;
    end
    if (cmd.out_ld) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_rec_r    <= res_rec_r;
      out_cnt_r    <= cnt_r;
    end
  end

  always_comb begin
    priority if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    priority if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.idx_end   = (idx_r == cnt_r);
    sts.key_gt    = (key_r > rkey);
    sts.match     = match_r;
    sts.full      = (cnt_r == CNT_W'(CAPACITY));
    sts.empty     = (cnt_r == '0);
    sts.j_gt_pos  = (j_r > pos_r);
    sts.j1_lt_cnt = (j_up < cnt_r);
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DW'({out_cnt_r, out_rec_r, out_key_r});

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending transaction");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (cnt_r < CNT_W'(CAPACITY)))
    else $error("insert into full table");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (cnt_r != '0))
    else $error("delete from empty table");

  a_shift_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && !cmd.wr_new) |-> $past(cmd.rd_en))
    else $error("shift write without preceding read");
`endif

endmodule

@@ design/sorted_key_index_table.sv @@
// Sorted key index table: (key, record number) pairs kept in ascending key order.
// Input channel in_*: one transaction per operation; in_tuser carries the op
// (insert, delete, lookup, clear, first), in_tdata the key and record number.
// Output channel out_*: exactly one transaction per operation with status in
// out_tuser and found key, found record and entry total in out_tdata.
// One operation is worked at a time; in_tready is high only while idle.
// Insert, delete and lookup first scan from the lowest entry past every
// smaller key; insert and delete then shift the later entries up or down.
// The single read port of the entry memory (read data registered) sets
// both the scan and the shift step.
// The result sits in an output register; a new operation is accepted while
// it waits, but the next result is held back until out_tready takes the old.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; entry memory itself is not cleared, no clearing pass is needed.
module sorted_key_index_table
  import skit_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [OP_W-1:0]   in_tuser,   // op
  input  logic [IN_DW-1:0]  in_tdata,   // key[31:0], record_number[47:32]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [STS_W-1:0]  out_tuser,  // status
  output logic [OUT_DW-1:0] out_tdata   // found_key[31:0], found_record[47:32],
                                        // entry_total[56:48], zero pad
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  skit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skit_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
